// ===== sv/htfc_pkg.sv =====
// ----------------------------------------------------------------------------
// htfc_pkg
// Shared types, register indexes, reset values and port widths for the
// humidity trend fan control unit.
// ----------------------------------------------------------------------------
package htfc_pkg;

  localparam int HUM_W         = 7;
  localparam int HOLD_W        = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 24;
  localparam int WINDOW_LEN_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HUM    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SEC   = 2'd3;

  localparam logic [HUM_W-1:0]  THRESHOLD_RST = 7'd5;
  localparam logic              FAN_ENABLE_RST = 1'b0;
  localparam logic [HUM_W-1:0]  MAX_HUM_RST   = 7'd70;
  localparam logic [HOLD_W-1:0] HOLD_SEC_RST  = 16'd600;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [1:0] {
    TREND_STABLE  = 2'd0,
    TREND_FALLING = 2'd1,
    TREND_RISING  = 2'd2
  } trend_t;

  typedef struct packed {
    logic [HUM_W-1:0]  threshold;
    logic              fan_enable;
    logic [HUM_W-1:0]  max_hum;
    logic [HOLD_W-1:0] hold_sec;
  } htfc_cfg_t;

  typedef struct packed {
    logic             mode;
    logic [HUM_W-1:0] humidity;
  } htfc_item_t;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_left;
    trend_t            trend;
    logic              fan_on;
  } htfc_result_t;

endpackage

// ===== sv/humidity_trend_fan_control_unit.sv =====
// ----------------------------------------------------------------------------
// humidity_trend_fan_control_unit
// Fan controller driven by a humidity trend over a window of recent samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer; in_tuser selects a humidity sample (0) or
//           a one-second tick (1); in_tdata carries the humidity.
//   out_* : exactly one result per item: fan state, trend and hold seconds
//           left after that item.
//   cfg_* : register writes take effect at the clock edge with cfg_we high;
//           write only while no item is in flight.
// A result passes through the input register, then the result register.
// Throughput: one item per cycle while the receiver takes results, set by the
// single combinational step from the input register to the result register.
// Reset clears the sample window, the hold counter and the fan state, and
// loads the register reset values. When the receiver stalls, the result
// register holds and one more item waits in the input register; in_tready
// drops only when both are full.
// ----------------------------------------------------------------------------
module humidity_trend_fan_control_unit import htfc_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [6:0] humidity
  input  logic                   in_tuser,   // [0] mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] fan_on, [2:1] trend, [18:3] hold_left
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  htfc_cfg_t    cfg;
  htfc_item_t   in_item;
  htfc_item_t   stage_item;
  htfc_result_t result;
  logic         stage_valid;
  logic         out_free;
  logic         advance;

  assign in_item.mode     = in_tuser;
  assign in_item.humidity = in_tdata[HUM_W-1:0];
  assign advance          = stage_valid && out_free;

  htfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  htfc_in_reg u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (in_item),
    .stage_free  (out_free),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  htfc_core #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (stage_item),
    .advance (advance),
    .result  (result)
  );

  htfc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ===== sv/htfc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// htfc_cfg_regs
// Configuration register file, written through the plain write port.
// ----------------------------------------------------------------------------
module htfc_cfg_regs import htfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output htfc_cfg_t             cfg
);

  htfc_cfg_t cfg_r;
  htfc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:  cfg_nxt.threshold  = cfg_wdata[HUM_W-1:0];
        CFG_FAN_ENABLE: cfg_nxt.fan_enable = cfg_wdata[0];
        CFG_MAX_HUM:    cfg_nxt.max_hum    = cfg_wdata[HUM_W-1:0];
        CFG_HOLD_SEC:   cfg_nxt.hold_sec   = cfg_wdata[HOLD_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= THRESHOLD_RST;
      cfg_r.fan_enable <= FAN_ENABLE_RST;
      cfg_r.max_hum    <= MAX_HUM_RST;
      cfg_r.hold_sec   <= HOLD_SEC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/htfc_in_reg.sv =====
// ----------------------------------------------------------------------------
// htfc_in_reg
// Input register: captures one item per transfer and holds it until the
// result stage takes it.
// ----------------------------------------------------------------------------
module htfc_in_reg import htfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  htfc_item_t in_item,
  input  logic       stage_free,
  output logic       stage_valid,
  output htfc_item_t stage_item
);

  logic       valid_r;
  logic       valid_nxt;
  htfc_item_t item_r;

  assign in_ready  = !valid_r || stage_free;
  assign valid_nxt = in_valid || (valid_r && !stage_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

// ===== sv/htfc_core.sv =====
// ----------------------------------------------------------------------------
// htfc_core
// Sample window, trend detection, fan state and hold counter. State moves
// forward once per item, when the item advances into the result register.
// ----------------------------------------------------------------------------
module htfc_core import htfc_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  htfc_cfg_t    cfg,
  input  htfc_item_t   item,
  input  logic         advance,
  output htfc_result_t result
);

  logic [HUM_W-1:0]  win_r   [WINDOW_LEN];
  logic [HUM_W-1:0]  win_nxt [WINDOW_LEN];
  logic [HOLD_W-1:0] hold_r;
  logic [HOLD_W-1:0] hold_nxt;
  logic              fan_r;
  logic              fan_nxt;

  logic [HUM_W-1:0]  oldest;
  logic [HUM_W-1:0]  newest;
  logic [HUM_W-1:0]  mag;
  trend_t            trend;

  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[WINDOW_LEN-1] = item.humidity;
  end

  always_comb begin
    if (item.mode == MODE_SAMPLE) begin
      oldest = win_r[1];
      newest = item.humidity;
    end else begin
      oldest = win_r[0];
      newest = win_r[WINDOW_LEN-1];
    end
    mag = (newest >= oldest) ? (newest - oldest) : (oldest - newest);
    priority if (oldest == '0) begin
      trend = TREND_STABLE;
    end else if (mag < cfg.threshold) begin
      trend = TREND_STABLE;
    end else if (newest < oldest) begin
      trend = TREND_FALLING;
    end else begin
      trend = TREND_RISING;
    end
  end

  always_comb begin
    fan_nxt  = fan_r;
    hold_nxt = hold_r;
    if (item.mode == MODE_SAMPLE) begin
      if (cfg.fan_enable && oldest != '0) begin
        if (trend == TREND_RISING || newest >= cfg.max_hum) begin
          fan_nxt  = 1'b1;
          hold_nxt = cfg.hold_sec;
        end else if (trend == TREND_STABLE && hold_r == '0) begin
          fan_nxt = 1'b0;
        end
      end
    end else if (hold_r != '0) begin
      if (hold_r == HOLD_W'(1)) begin
        fan_nxt = 1'b0;
      end
      hold_nxt = hold_r - HOLD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
      hold_r <= '0;
      fan_r  <= 1'b0;
    end else if (advance) begin
      if (item.mode == MODE_SAMPLE) begin
        win_r <= win_nxt;
      end
      hold_r <= hold_nxt;
      fan_r  <= fan_nxt;
    end
  end

  assign result.fan_on    = fan_nxt;
  assign result.trend     = trend;
  assign result.hold_left = hold_nxt;

endmodule

// ===== sv/htfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// htfc_out_reg
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module htfc_out_reg import htfc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  htfc_result_t           result,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  logic         valid_r;
  logic         valid_nxt;
  htfc_result_t result_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = OUT_TDATA_W'({result_r.hold_left, result_r.trend, result_r.fan_on});

endmodule

// ===== sv/htfc_checker.sv =====
// ----------------------------------------------------------------------------
// htfc_checker
// Port-level checks for the humidity trend fan control unit.
// ----------------------------------------------------------------------------
module htfc_checker import htfc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_hold_implies_fan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18:3] != 16'd0 |-> out_tdata[0])
    else $error("hold time left with fan off");

endmodule

bind humidity_trend_fan_control_unit htfc_checker u_htfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/htfc_fan_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htfc_fan_checker
// Watches the input, result and register ports of the humidity trend fan
// control unit. It keeps its own copy of the sample window, hold counter, fan
// state and registers, predicts one result per input transfer and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module htfc_fan_checker import htfc_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatch_count,
  output int                     results_pending
);

  logic [HUM_W-1:0]  window [WINDOW_LEN];
  logic [HOLD_W-1:0] hold_cnt;
  logic              fan;
  htfc_cfg_t         regs;
  htfc_result_t      fan_result_q[$];
  logic              in_xfer;
  logic              out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  task automatic report_error(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic trend_t window_trend();
    logic [HUM_W-1:0] oldest;
    logic [HUM_W-1:0] newest;
    logic [HUM_W-1:0] mag;
    oldest = window[0];
    newest = window[WINDOW_LEN-1];
    if (oldest == '0) return TREND_STABLE;
    mag = (newest >= oldest) ? newest - oldest : oldest - newest;
    if (mag < regs.threshold) return TREND_STABLE;
    if (newest < oldest) return TREND_FALLING;
    return TREND_RISING;
  endfunction

  task automatic predict_fan(htfc_item_t item);
    trend_t       tr;
    htfc_result_t res;
    if (item.mode == MODE_SAMPLE) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] = window[i+1];
      window[WINDOW_LEN-1] = item.humidity;
      tr = window_trend();
      if (regs.fan_enable && window[0] != '0) begin
        if (tr == TREND_RISING || window[WINDOW_LEN-1] >= regs.max_hum) begin
          fan = 1'b1;
          hold_cnt = regs.hold_sec;
        end else if (tr == TREND_STABLE && hold_cnt == '0) begin
          fan = 1'b0;
        end
      end
    end else begin
      if (hold_cnt != '0) begin
        if (hold_cnt == HOLD_W'(1)) fan = 1'b0;
        hold_cnt = hold_cnt - 1'b1;
      end
      tr = window_trend();
    end
    res.fan_on    = fan;
    res.trend     = tr;
    res.hold_left = hold_cnt;
    fan_result_q.push_back(res);
  endtask

  task automatic check_result(logic [OUT_TDATA_W-1:0] data);
    htfc_result_t got;
    htfc_result_t want;
    got = htfc_result_t'(data[$bits(htfc_result_t)-1:0]);
    if (fan_result_q.size() == 0) begin
      report_error($sformatf("result with none expected, tdata 0x%0h", data));
      return;
    end
    want = fan_result_q.pop_front();
    if (got.fan_on != want.fan_on)
      report_error($sformatf("fan_on got %0d, want %0d", got.fan_on, want.fan_on));
    if (got.trend != want.trend)
      report_error($sformatf("trend got %0d, want %0d", got.trend, want.trend));
    if (got.hold_left != want.hold_left)
      report_error($sformatf("hold_left got %0d, want %0d", got.hold_left, want.hold_left));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (window[i]) window[i] = '0;
      hold_cnt = '0;
      fan = 1'b0;
      regs.threshold  = THRESHOLD_RST;
      regs.fan_enable = FAN_ENABLE_RST;
      regs.max_hum    = MAX_HUM_RST;
      regs.hold_sec   = HOLD_SEC_RST;
      fan_result_q.delete();
      results_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD:  regs.threshold  = cfg_wdata[HUM_W-1:0];
          CFG_FAN_ENABLE: regs.fan_enable = cfg_wdata[0];
          CFG_MAX_HUM:    regs.max_hum    = cfg_wdata[HUM_W-1:0];
          CFG_HOLD_SEC:   regs.hold_sec   = cfg_wdata[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (out_xfer) check_result(out_tdata);
      if (in_xfer) predict_fan('{mode: in_tuser, humidity: in_tdata[HUM_W-1:0]});
      results_pending <= results_pending + int'(in_xfer) - int'(out_xfer);
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the humidity trend fan control unit. A directed
// run covers field extremes, zero samples, countdown and falling trends; then
// random sample and tick streams run under a series of register settings
// with random gaps and result stalls. Checking lives in htfc_fan_checker.
// ----------------------------------------------------------------------------
module testbench;
  import htfc_pkg::*;

  localparam int PHASES     = 7;
  localparam int PHASE_ITEMS = 85;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [6:0] humidity
  logic                   in_tuser = 1'b0; // [0] mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [0] fan_on, [2:1] trend, [18:3] hold_left
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  int                     mismatch_count;
  int                     results_pending;
  bit                     no_gaps = 1'b0;
  htfc_cfg_t              phase_cfg [PHASES];
  int                     base_hum = 40;

  always #5 clk = ~clk;

  humidity_trend_fan_control_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  htfc_fan_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic mode, logic [HUM_W-1:0] hum);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {1'b0, hum};
    @(posedge clk iff in_tready);
  endtask

  task automatic send_sample(int hum);
    send_item(MODE_SAMPLE, HUM_W'(hum));
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, HUM_W'($urandom_range(0, 127)));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(htfc_cfg_t c);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(c.threshold);
    @(posedge clk);
    cfg_index <= CFG_FAN_ENABLE;
    cfg_wdata <= CFG_DATA_W'(c.fan_enable);
    @(posedge clk);
    cfg_index <= CFG_MAX_HUM;
    cfg_wdata <= CFG_DATA_W'(c.max_hum);
    @(posedge clk);
    cfg_index <= CFG_HOLD_SEC;
    cfg_wdata <= c.hold_sec;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_tick();
    end else if (r < 38) begin
      send_sample(0);
    end else if (r < 44) begin
      send_sample($urandom_range(0, 127));
    end else begin
      base_hum = base_hum + int'($urandom_range(0, 12)) - 5;
      if (base_hum < 1) base_hum = 1;
      if (base_hum > 127) base_hum = 127;
      send_sample(base_hum);
    end
  endtask

  // Result-side backpressure: short stalls, occasional long ones, and long
  // stretches with no stall at all.
  initial begin
    int r;
    forever begin
      r = $urandom_range(0, 99);
      out_tready <= 1'b1;
      if (r < 10) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_tready <= 1'b0;
        repeat (r < 85 ? $urandom_range(1, 3) : $urandom_range(10, 50)) @(posedge clk);
      end
    end
  end

  initial begin
    int ramp [8] = '{10, 12, 14, 16, 18, 20, 22, 40};
    phase_cfg[0] = '{threshold: 7'd0,   fan_enable: 1'b1, max_hum: 7'd0,   hold_sec: 16'd0};
    phase_cfg[1] = '{threshold: 7'd127, fan_enable: 1'b1, max_hum: 7'd127, hold_sec: 16'hFFFF};
    phase_cfg[2] = '{threshold: 7'd20,  fan_enable: 1'b1, max_hum: 7'd127, hold_sec: 16'd0};
    phase_cfg[3] = '{threshold: 7'd5,   fan_enable: 1'b1, max_hum: 7'd70,  hold_sec: 16'd4};
    phase_cfg[4] = '{threshold: 7'd100, fan_enable: 1'b0, max_hum: 7'd100, hold_sec: 16'd1};
    phase_cfg[5] = '{threshold: 7'd3,   fan_enable: 1'b1, max_hum: 7'd60,  hold_sec: 16'd2};
    phase_cfg[6] = '{threshold: 7'($urandom_range(0, 100)), fan_enable: 1'($urandom),
                     max_hum: 7'($urandom_range(0, 100)), hold_sec: 16'($urandom_range(0, 8))};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, fan disabled
    send_sample(0);
    send_sample(127);
    send_tick();
    send_sample(100);

    write_regs('{threshold: 7'd5, fan_enable: 1'b1, max_hum: 7'd70, hold_sec: 16'd3});
    foreach (ramp[i]) send_sample(ramp[i]);
    repeat (4) send_tick();
    send_sample(5);
    // zero in the oldest slot keeps the trend stable and the fan untouched
    send_sample(0);
    repeat (6) send_sample(50);
    send_sample(80);

    for (int p = 0; p < PHASES; p++) begin
      write_regs(phase_cfg[p]);
      no_gaps = (p == 3);
      repeat (PHASE_ITEMS) random_item();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
